FILE: design/bmm_pkg.sv
package bmm_pkg;

   // Defaults for the top-level parameters
   localparam int RAM_BANKS_DEF = 4;
   localparam int ROM_PAGES_DEF = 4;

   // Address map
   localparam int PAGE_AW      = 11;
   localparam int BANK_AW      = 16;
   localparam int CMOS_DEPTH   = 2048;
   localparam logic [4:0] BANKED_PAGES = 5'd28;
   localparam logic [4:0] CMOS_PAGE    = 5'd16;

   // I/O port bases, each decodes a group of four ports
   localparam logic [7:0] PORT_BANK = 8'h18;
   localparam logic [7:0] PORT_ROM  = 8'h1c;
   localparam logic [7:0] PORT_CMOS = 8'h20;
   localparam logic [7:0] PORT_FDC  = 8'h30;

   localparam logic [7:0] BYTE_FF   = 8'hff;
   localparam logic [7:0] BANK_BITS = 8'hf0;

   // Packed widths of the stream payloads
   localparam int REQ_W = 40;
   localparam int RSP_W = 16;

   typedef enum logic [2:0] {
      ACT_MEM_READ  = 3'd0,
      ACT_MEM_WRITE = 3'd1,
      ACT_IO_READ   = 3'd2,
      ACT_IO_WRITE  = 3'd3,
      ACT_ROM_LOAD  = 3'd4
   } action_type;

   // Where the result byte of an item comes from
   typedef enum logic [1:0] {
      SRC_FIXED = 2'd0,
      SRC_RAM   = 2'd1,
      SRC_ROM   = 2'd2,
      SRC_CMOS  = 2'd3
   } src_type;

endpackage

FILE: design/banked_memory_mapper_top.sv
// Pipeline: a request transfer passes through stage 1 (memory read) and then the output
//   register to its result transfer; one request per cycle is sustained while rsp_tready is high.
// After reset a clearing pass over every RAM address zeroes RAM and CMOS and fills
//   the boot ROM with 0xFF; req_tready stays low for that time, csr writes are taken.
// Reset: bank register 0x10, ROM select on, CMOS select off, dip switch 0.
module banked_memory_mapper_top import bmm_pkg::*; #(
   parameter int RAM_BANKS = RAM_BANKS_DEF,
   parameter int ROM_PAGES = ROM_PAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // action[2:0], address[18:3], write_data[26:19], floppy_status[34:27], zero pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // read_data[7:0], speaker_gate[8], soft_timer_gate[9], beep_enable[10], zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   localparam int RAM_DEPTH = RAM_BANKS * (1 << BANK_AW);
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam int ROM_DEPTH = ROM_PAGES * (1 << PAGE_AW);
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam logic [4:0] ROM_PAGES_L = 5'(ROM_PAGES);
   localparam logic [2:0] RAM_BANKS_L = 3'(RAM_BANKS);

   // Stores
   logic [7:0] ram_mem  [RAM_DEPTH];
   logic [7:0] rom_mem  [ROM_DEPTH];
   logic [7:0] cmos_mem [CMOS_DEPTH];

   logic [7:0] ram_rd_ff, rom_rd_ff, cmos_rd_ff;

   // Control and configuration
   logic              clearing_ff;
   logic [RAM_AW-1:0] clr_cnt_ff;
   logic [7:0]        dip_ff;
   logic [7:0]        bank_ff, bank_in;
   logic              rom_sel_ff, rom_sel_in;
   logic              cmos_sel_ff, cmos_sel_in;

   // Stage 1: memory access issued
   logic       s1_valid_ff;
   src_type    s1_src_ff, s1_src_in;
   logic [7:0] s1_fixed_ff, s1_fixed_in;
   logic [2:0] s1_gates_ff;

   // Output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic [2:0] rsp_gates_ff;

   // Request fields
   logic [2:0]  req_action;
   logic [15:0] req_addr;
   logic [7:0]  req_wdata;
   logic [7:0]  req_fdc;
   logic [4:0]  page;
   logic [7:0]  port;

   logic accept, advance;

   // Store port controls
   logic              ram_we, ram_re, rom_we, rom_re, cmos_we, cmos_re;
   logic [RAM_AW-1:0] ram_addr;
   logic [ROM_AW-1:0] rom_addr;
   logic [10:0]       cmos_addr;
   logic [7:0]        ram_wdata, rom_wdata, cmos_wdata;

   // Decode results
   logic              hit_ram, hit_rom, hit_cmos;
   logic [17:0]       ram_full;
   logic [1:0]        bank_idx;
   logic              bank_any;

   assign req_action = req_tdata[2:0];
   assign req_addr   = req_tdata[18:3];
   assign req_wdata  = req_tdata[26:19];
   assign req_fdc    = req_tdata[34:27];
   assign page       = req_addr[15:11];
   assign port       = req_addr[7:0];

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clearing_ff && (!s1_valid_ff || advance);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_gates_ff, rsp_data_ff};

   // Lowest set bank select bit
   always_comb begin
      bank_any = 1'b1;
      bank_idx = 2'd0;
      priority if (bank_ff[4]) bank_idx = 2'd0;
      else if (bank_ff[5]) bank_idx = 2'd1;
      else if (bank_ff[6]) bank_idx = 2'd2;
      else if (bank_ff[7]) bank_idx = 2'd3;
      else bank_any = 1'b0;
   end

   // Page decode
   always_comb begin
      hit_rom  = 1'b0;
      hit_cmos = 1'b0;
      hit_ram  = 1'b0;
      ram_full = {2'd0, req_addr};
      priority if (rom_sel_ff && (page < ROM_PAGES_L)) begin
         hit_rom = 1'b1;
      end else if (cmos_sel_ff && (page == CMOS_PAGE)) begin
         hit_cmos = 1'b1;
      end else if (page >= BANKED_PAGES) begin
         hit_ram = 1'b1;
      end else if (bank_any && ({1'b0, bank_idx} < RAM_BANKS_L)) begin
         hit_ram  = 1'b1;
         ram_full = {bank_idx, req_addr};
      end else begin
         hit_ram = 1'b0;
      end
   end

   // Register updates, I/O reads and result source
   always_comb begin
      bank_in     = bank_ff;
      rom_sel_in  = rom_sel_ff;
      cmos_sel_in = cmos_sel_ff;
      s1_src_in   = SRC_FIXED;
      s1_fixed_in = BYTE_FF;
      unique case (req_action)
         ACT_MEM_READ: begin
            priority if (hit_rom) s1_src_in = SRC_ROM;
            else if (hit_cmos) s1_src_in = SRC_CMOS;
            else if (hit_ram) s1_src_in = SRC_RAM;
            else s1_src_in = SRC_FIXED;
         end
         ACT_IO_READ: begin
            priority if (port[7:2] == PORT_BANK[7:2]) s1_fixed_in = dip_ff;
            else if (port[7:2] == PORT_FDC[7:2]) s1_fixed_in = (bank_ff & BANK_BITS) | req_fdc;
            else s1_fixed_in = BYTE_FF;
         end
         ACT_IO_WRITE: begin
            priority if (port[7:2] == PORT_BANK[7:2]) bank_in = req_wdata;
            else if (port[7:2] == PORT_ROM[7:2]) rom_sel_in = !req_wdata[0];
            else if (port[7:2] == PORT_CMOS[7:2]) cmos_sel_in = req_wdata[0];
            else bank_in = bank_ff;
         end
         default: begin
            s1_fixed_in = BYTE_FF;
         end
      endcase
   end

   // Store port muxes: clearing pass or request access
   always_comb begin
      ram_addr   = ram_full[RAM_AW-1:0];
      rom_addr   = req_addr[ROM_AW-1:0];
      cmos_addr  = req_addr[10:0];
      ram_wdata  = req_wdata;
      rom_wdata  = req_wdata;
      cmos_wdata = req_wdata;
      ram_re     = accept && (req_action == ACT_MEM_READ) && hit_ram;
      rom_re     = accept && (req_action == ACT_MEM_READ) && hit_rom;
      cmos_re    = accept && (req_action == ACT_MEM_READ) && hit_cmos;
      ram_we     = accept && (req_action == ACT_MEM_WRITE) && hit_ram;
      cmos_we    = accept && (req_action == ACT_MEM_WRITE) && hit_cmos;
      rom_we     = accept && (req_action == ACT_ROM_LOAD)
                   && ({1'b0, req_addr} < 17'(ROM_DEPTH));
      if (clearing_ff) begin
         ram_addr   = clr_cnt_ff;
         rom_addr   = clr_cnt_ff[ROM_AW-1:0];
         cmos_addr  = clr_cnt_ff[10:0];
         ram_wdata  = 8'd0;
         rom_wdata  = BYTE_FF;
         cmos_wdata = 8'd0;
         ram_we     = 1'b1;
         rom_we     = clr_cnt_ff < RAM_AW'(ROM_DEPTH);
         cmos_we    = clr_cnt_ff < RAM_AW'(CMOS_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) ram_mem[ram_addr] <= ram_wdata;
      if (ram_re) ram_rd_ff <= ram_mem[ram_addr];
   end

   always_ff @(posedge clock) begin
      if (rom_we) rom_mem[rom_addr] <= rom_wdata;
      if (rom_re) rom_rd_ff <= rom_mem[rom_addr];
   end

   always_ff @(posedge clock) begin
      if (cmos_we) cmos_mem[cmos_addr] <= cmos_wdata;
      if (cmos_re) cmos_rd_ff <= cmos_mem[cmos_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         dip_ff       <= 8'd0;
         bank_ff      <= 8'h10;
         rom_sel_ff   <= 1'b1;
         cmos_sel_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == RAM_AW'(RAM_DEPTH - 1)) clearing_ff <= 1'b0;
         end
         if (csr_valid) dip_ff <= csr_data;
         if (accept) begin
            bank_ff     <= bank_in;
            rom_sel_ff  <= rom_sel_in;
            cmos_sel_ff <= cmos_sel_in;
         end
         if (accept) s1_valid_ff <= 1'b1;
         else if (advance) s1_valid_ff <= 1'b0;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_src_ff   <= s1_src_in;
         s1_fixed_ff <= s1_fixed_in;
         s1_gates_ff <= bank_in[2:0];
      end
      if (advance) begin
         rsp_gates_ff <= s1_gates_ff;
         unique case (s1_src_ff)
            SRC_RAM:  rsp_data_ff <= ram_rd_ff;
            SRC_ROM:  rsp_data_ff <= rom_rd_ff;
            SRC_CMOS: rsp_data_ff <= cmos_rd_ff;
            default:  rsp_data_ff <= s1_fixed_ff;
         endcase
      end
   end

   // Nothing in flight while the stores are being cleared
   assert property (@(posedge clock) clearing_ff |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("item in flight during clearing pass");

   // Request-side writes to RAM happen only with a request transfer
   assert property (@(posedge clock) disable iff (reset)
      (ram_we && !clearing_ff) |-> accept)
      else $error("RAM write without request transfer");

   // A waiting stage-1 item moves to an empty output register
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("stage 1 item not advanced");

   // Bank register write shows in the gates of the same item
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_IO_WRITE) && (port[7:2] == PORT_BANK[7:2]))
      |=> (s1_gates_ff == $past(req_wdata[2:0])))
      else $error("gate bits do not follow bank write");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top import bmm_pkg::*;;

   localparam int RAM_DEPTH = RAM_BANKS_DEF << BANK_AW;
   localparam int ROM_DEPTH = ROM_PAGES_DEF << PAGE_AW;
   localparam int ACT_RSVD_LO = 5;
   localparam int ACT_RSVD_HI = 7;
   localparam int HOT_SLOTS = 16;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 285;
   localparam int MAX_REPORTS = 10;

   // last field in the lowest bits
   typedef struct packed {
      logic [7:0]  fdc;
      logic [7:0]  wdata;
      logic [15:0] address;
      logic [2:0]  act;
   } req_type;

   typedef struct packed {
      logic       beep_enable;
      logic       soft_timer_gate;
      logic       speaker_gate;
      logic [7:0] read_data;
   } rsp_type;

   // exp_gates is {beep_enable, soft_timer_gate, speaker_gate}
   typedef struct packed {
      logic [2:0]  act;
      logic [15:0] address;
      logic [7:0]  wdata;
      logic [7:0]  fdc;
      logic        typed;
      logic [7:0]  exp_rd;
      logic [2:0]  exp_gates;
   } dir_row_type;

   localparam int DIR_ROWS = 28;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{ACT_MEM_READ,  16'h0000, 8'h00, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_IO_READ,   16'h0018, 8'h00, 8'h00, 1'b1, 8'h00, 3'b000},
      '{ACT_IO_READ,   16'hff30, 8'h00, 8'h0f, 1'b1, 8'h1f, 3'b000},
      '{ACT_IO_READ,   16'h0055, 8'h00, 8'hff, 1'b1, 8'hff, 3'b000},
      '{ACT_MEM_READ,  16'hffff, 8'h00, 8'h00, 1'b1, 8'h00, 3'b000},
      '{ACT_MEM_WRITE, 16'hffff, 8'ha5, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_MEM_READ,  16'hffff, 8'h00, 8'h00, 1'b0, 8'h00, 3'b000},
      '{ACT_ROM_LOAD,  16'h1fff, 8'h3c, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_ROM_LOAD,  16'h2000, 8'hc3, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_MEM_READ,  16'h1fff, 8'h00, 8'h00, 1'b0, 8'h00, 3'b000},
      '{ACT_MEM_WRITE, 16'h0000, 8'h77, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_MEM_READ,  16'h0000, 8'h00, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_IO_WRITE,  16'h001d, 8'h01, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_MEM_READ,  16'h1fff, 8'h00, 8'h00, 1'b0, 8'h00, 3'b000},
      '{ACT_IO_WRITE,  16'h0023, 8'h01, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_MEM_WRITE, 16'h87ff, 8'h5a, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_MEM_READ,  16'h87ff, 8'h00, 8'h00, 1'b0, 8'h00, 3'b000},
      '{ACT_IO_WRITE,  16'h0018, 8'h07, 8'h00, 1'b1, 8'hff, 3'b111},
      '{ACT_MEM_READ,  16'h4000, 8'h00, 8'h00, 1'b1, 8'hff, 3'b111},
      '{ACT_MEM_READ,  16'he000, 8'h00, 8'h00, 1'b0, 8'h00, 3'b000},
      '{ACT_IO_READ,   16'h0033, 8'h00, 8'h00, 1'b1, 8'h00, 3'b111},
      '{ACT_IO_WRITE,  16'h001b, 8'h80, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_MEM_WRITE, 16'h4000, 8'hff, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_MEM_READ,  16'h4000, 8'h00, 8'h00, 1'b0, 8'h00, 3'b000},
      '{ACT_IO_WRITE,  16'h001c, 8'h00, 8'h00, 1'b1, 8'hff, 3'b000},
      '{3'(ACT_RSVD_LO), 16'hffff, 8'hff, 8'hff, 1'b1, 8'hff, 3'b000},
      '{3'(ACT_RSVD_HI), 16'h0000, 8'h00, 8'h00, 1'b1, 8'hff, 3'b000},
      '{ACT_IO_WRITE,  16'h00ff, 8'hff, 8'h00, 1'b1, 8'hff, 3'b000}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [7:0]       csr_data = 8'h00;

   // mapper image kept by the testbench
   logic [7:0] dip_val;
   logic [7:0] bank_reg;
   logic       rom_sel;
   logic       cmos_sel;
   logic [7:0] ram_img [RAM_DEPTH];
   logic [7:0] rom_img [ROM_DEPTH];
   logic [7:0] cmos_img [CMOS_DEPTH];

   logic [15:0] hot_addr [HOT_SLOTS];
   bit          idle_on = 1'b0;
   rsp_type     rsp_expect_q [$];
   rsp_type     got_rsp;
   rsp_type     want_rsp;
   int unsigned mism_count = 0;

   banked_memory_mapper_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Apply one access to the image and return the byte and gates it yields.
   function automatic rsp_type map_access(input req_type r);
      rsp_type     res;
      src_type     kind;
      int unsigned off;
      logic [4:0]  page;
      logic [7:0]  port;
      logic        found;
      int          b;
      page = r.address[15:11];
      port = r.address[7:0];
      kind = SRC_FIXED;
      off = r.address;
      found = 1'b0;
      res.read_data = BYTE_FF;
      if (rom_sel && page < ROM_PAGES_DEF) begin
         kind = SRC_ROM;
      end else if (cmos_sel && page == CMOS_PAGE) begin
         kind = SRC_CMOS;
         off = r.address[PAGE_AW-1:0];
      end else if (page >= BANKED_PAGES) begin
         kind = SRC_RAM;
      end else begin
         // lowest set select bit wins
         for (b = 0; b < 4; b++) begin
            if (!found && bank_reg[4+b]) begin
               found = 1'b1;
               if (b < RAM_BANKS_DEF) begin
                  kind = SRC_RAM;
                  off = (b << BANK_AW) + r.address;
               end
            end
         end
      end
      case (r.act)
         ACT_MEM_READ: begin
            case (kind)
               SRC_RAM:  res.read_data = ram_img[off];
               SRC_ROM:  res.read_data = rom_img[off];
               SRC_CMOS: res.read_data = cmos_img[off];
               default: ;
            endcase
         end
         ACT_MEM_WRITE: begin
            if (kind == SRC_RAM)
               ram_img[off] = r.wdata;
            else if (kind == SRC_CMOS)
               cmos_img[off] = r.wdata;
         end
         ACT_IO_READ: begin
            if (port[7:2] == PORT_BANK[7:2])
               res.read_data = dip_val;
            else if (port[7:2] == PORT_FDC[7:2])
               res.read_data = (bank_reg & BANK_BITS) | r.fdc;
         end
         ACT_IO_WRITE: begin
            if (port[7:2] == PORT_BANK[7:2])
               bank_reg = r.wdata;
            else if (port[7:2] == PORT_ROM[7:2])
               rom_sel = ~r.wdata[0];
            else if (port[7:2] == PORT_CMOS[7:2])
               cmos_sel = r.wdata[0];
         end
         ACT_ROM_LOAD: begin
            if (r.address < ROM_DEPTH)
               rom_img[r.address] = r.wdata;
         end
         default: ;
      endcase
      res.speaker_gate = bank_reg[0];
      res.soft_timer_gate = bank_reg[1];
      res.beep_enable = bank_reg[2];
      return res;
   endfunction

   // Most accesses reuse a small set of addresses so reads find earlier writes.
   function automatic req_type make_access();
      req_type     r;
      int unsigned pick;
      r.wdata = 8'($urandom);
      r.fdc = 8'($urandom);
      if ($urandom_range(0, 7) == 0)
         hot_addr[$urandom_range(0, HOT_SLOTS - 1)] = 16'($urandom);
      if ($urandom_range(0, 2) == 0)
         r.address = 16'($urandom);
      else
         r.address = hot_addr[$urandom_range(0, HOT_SLOTS - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
         r.act = ACT_MEM_READ;
      end else if (pick < 57) begin
         r.act = ACT_MEM_WRITE;
      end else if (pick < 70) begin
         r.act = ACT_IO_READ;
         case ($urandom_range(0, 2))
            0: r.address[7:0] = PORT_BANK | 8'($urandom_range(0, 3));
            1: r.address[7:0] = PORT_FDC | 8'($urandom_range(0, 3));
            default: ;
         endcase
      end else if (pick < 85) begin
         r.act = ACT_IO_WRITE;
         case ($urandom_range(0, 3))
            0: begin
               r.address[7:0] = PORT_BANK | 8'($urandom_range(0, 3));
               if ($urandom_range(0, 3) == 0)
                  r.wdata[7:4] = 4'h0;
            end
            1: r.address[7:0] = PORT_ROM | 8'($urandom_range(0, 3));
            2: r.address[7:0] = PORT_CMOS | 8'($urandom_range(0, 3));
            default: ;
         endcase
      end else if (pick < 95) begin
         r.act = ACT_ROM_LOAD;
         if ($urandom_range(0, 3) != 0)
            r.address[15:13] = 3'b000;
      end else begin
         r.act = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
      end
      return r;
   endfunction

   task automatic transfer_req(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type pred;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata <= REQ_W'(r);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = map_access(r);
      rsp_expect_q.push_back(typed ? typed_rsp : pred);
   endtask

   task automatic write_dip(input logic [7:0] v);
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      dip_val = v;
   endtask

   initial begin : rsp_stall_gen
      int unsigned hold_cycles;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles != 0)
            hold_cycles--;
         else if (idle_on && $urandom_range(0, 5) == 0)
            hold_cycles = $urandom_range(1, 4);
         rsp_tready <= (hold_cycles == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = rsp_type'(rsp_tdata[10:0]);
         if (rsp_expect_q.size() == 0) begin
            mism_count++;
            if (mism_count <= MAX_REPORTS)
               $display("unexpected result transfer: read_data %h gates %b%b%b",
                        got_rsp.read_data, got_rsp.beep_enable,
                        got_rsp.soft_timer_gate, got_rsp.speaker_gate);
         end else begin
            want_rsp = rsp_expect_q.pop_front();
            if (got_rsp.read_data !== want_rsp.read_data
                || got_rsp.speaker_gate !== want_rsp.speaker_gate
                || got_rsp.soft_timer_gate !== want_rsp.soft_timer_gate
                || got_rsp.beep_enable !== want_rsp.beep_enable) begin
               mism_count++;
               if (mism_count <= MAX_REPORTS)
                  $display("mismatch at %0t: read_data exp %h got %h, gates exp %b%b%b got %b%b%b",
                           $realtime, want_rsp.read_data, got_rsp.read_data,
                           want_rsp.beep_enable, want_rsp.soft_timer_gate,
                           want_rsp.speaker_gate, got_rsp.beep_enable,
                           got_rsp.soft_timer_gate, got_rsp.speaker_gate);
            end
         end
      end
   end

   initial begin : stimulus
      int i;
      int phase;
      dip_val = 8'h00;
      bank_reg = 8'h10;
      rom_sel = 1'b1;
      cmos_sel = 1'b0;
      for (i = 0; i < RAM_DEPTH; i++) ram_img[i] = 8'h00;
      for (i = 0; i < ROM_DEPTH; i++) rom_img[i] = BYTE_FF;
      for (i = 0; i < CMOS_DEPTH; i++) cmos_img[i] = 8'h00;
      for (i = 0; i < HOT_SLOTS; i++) hot_addr[i] = 16'($urandom);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      for (i = 0; i < DIR_ROWS; i++)
         transfer_req({DIR_TABLE[i].fdc, DIR_TABLE[i].wdata, DIR_TABLE[i].address,
                       DIR_TABLE[i].act}, DIR_TABLE[i].typed,
                      rsp_type'({DIR_TABLE[i].exp_gates, DIR_TABLE[i].exp_rd}));
      req_tvalid <= 1'b0;
      while (rsp_expect_q.size() != 0) @(posedge clock);

      for (phase = 0; phase < PHASES; phase++) begin
         // switch the dip setting only while nothing is in flight
         if (phase == 0)
            write_dip(8'hff);
         else if (phase == 1)
            write_dip(8'h00);
         else
            write_dip(8'($urandom));
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 95 == 0)
               idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            transfer_req(make_access(), 1'b0, '0);
         end
         req_tvalid <= 1'b0;
         while (rsp_expect_q.size() != 0) @(posedge clock);
      end

      // catch any stray result after the last one
      repeat (8) @(posedge clock);
      if (mism_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
